// ===== src/bra_pkg.sv =====
// Shared constants, types and codes of the resource allocator.
package bra_pkg;

    // Sizes of the stored tables
    localparam int MAX_PROCESSES = 8;
    localparam int NUM_RES       = 3;
    localparam int COUNT_WIDTH   = 8;
    localparam int WORK_WIDTH    = COUNT_WIDTH + 4;
    localparam int ROW_W         = 3;
    localparam int ROWS_W        = 4;
    localparam int CFG_W         = 4;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = 2;
    localparam int QCNT_W        = 3;

    localparam logic [CFG_W-1:0]      CFG_RESET = CFG_W'(5);
    localparam logic [ROWS_W-1:0]     ROW_LIMIT = ROWS_W'(MAX_PROCESSES < 8 ? MAX_PROCESSES : 8);
    localparam logic [WORK_WIDTH-1:0] WORK_MAX  = {WORK_WIDTH{1'b1}};

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [WORK_WIDTH-1:0]  work_t;
    typedef logic [ROW_W-1:0]       row_t;
    typedef logic [ROWS_W-1:0]      rows_t;

    // Input actions
    typedef enum logic [1:0] {
        OP_LOAD_AVAIL = 2'd0,
        OP_LOAD_ROW   = 2'd1,
        OP_REQUEST    = 2'd2,
        OP_SAFETY     = 2'd3
    } op_t;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_REQ_VERDICT = 2'd0,
        KIND_SEQ_ENTRY   = 2'd1,
        KIND_SAFETY      = 2'd2
    } kind_t;

    // Request verdict codes
    typedef enum logic [1:0] {
        VC_GRANTED     = 2'd0,
        VC_OVER_NEED   = 2'd1,
        VC_OVER_AVAIL  = 2'd2,
        VC_BAD_PROCESS = 2'd3
    } verdict_t;

    // Classified command; for a row load, val carries the computed need
    typedef struct packed {
        op_t                     op;
        logic                    bad_row;
        row_t                    proc;
        count_t [NUM_RES-1:0]    val;
        count_t [NUM_RES-1:0]    alo;
    } cmd_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic empty;
        logic full;
    } queue_stat_t;

endpackage

// ===== src/bra_ifs.sv =====
// Valid/ready channel interfaces for requests and results.
interface bra_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [2:0] process;
    logic [7:0] value_a;
    logic [7:0] value_b;
    logic [7:0] value_c;
    logic [7:0] alloc_a;
    logic [7:0] alloc_b;
    logic [7:0] alloc_c;

    modport source (
        output valid, action, process, value_a, value_b, value_c,
               alloc_a, alloc_b, alloc_c,
        input  ready
    );
    modport sink (
        input  valid, action, process, value_a, value_b, value_c,
               alloc_a, alloc_b, alloc_c,
        output ready
    );
endinterface

interface bra_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [1:0] verdict_code;
    logic [2:0] sequence_process;
    logic       is_safe;
    logic       last;

    modport source (
        output valid, kind, verdict_code, sequence_process, is_safe, last,
        input  ready
    );
    modport sink (
        input  valid, kind, verdict_code, sequence_process, is_safe, last,
        output ready
    );
endinterface

// ===== src/bankers_resource_allocator.sv =====
// Top level of the three-resource Banker's algorithm allocator.
//
// Channels: requests (sink) carries action, process, value_a..c and
// alloc_a..c; results (source) carries kind, verdict_code,
// sequence_process, is_safe and last. Both move one item per cycle in
// which valid and ready are high. cfg_wr_en/cfg_wr_data write
// processes_in_use (reset 5); write it only while the block is idle.
// A request is taken whenever the four-entry command queue has room.
// Loads take effect as they leave the queue, and give no result. A
// resource request gives its verdict in the result register as it
// leaves the queue, and requests can stream at one per cycle while
// results.ready stays high. A safety check starts as it leaves the
// queue, visits rows in a round-robin scan (at most n*n visits for n
// rows) and then gives its verdict; the scan unit tests one row per
// cycle while the result register is free. Reset clears the tables, the
// queue and the result register at once. If results.ready is low, the
// result waits in its register, the back part stalls at its next request,
// safety check or scan step, and the queue keeps taking requests until full.
module bankers_resource_allocator (
    input  logic                       clk,
    input  logic                       rst_n,
    bra_req_if.sink                    requests,
    bra_res_if.source                  results,
    input  logic                       cfg_wr_en,
    input  logic [bra_pkg::CFG_W-1:0]  cfg_wr_data
);
    import bra_pkg::*;

    logic [CFG_W-1:0] procs_reg;
    rows_t            rows;
    logic             push;
    cmd_t             push_cmd;
    logic             pop;
    cmd_t             head;
    queue_stat_t      q_stat;

    // Hold the row count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            procs_reg <= CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            procs_reg <= cfg_wr_data;
        end
    end

    // Clamp the row count to the stored rows
    assign rows = (procs_reg > ROW_LIMIT) ? ROW_LIMIT : procs_reg;

    bra_front u_front (
        .requests (requests),
        .rows     (rows),
        .q_stat   (q_stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    bra_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    bra_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .rows     (rows),
        .head     (head),
        .q_stat   (q_stat),
        .pop      (pop),
        .results  (results)
    );

endmodule

// ===== src/bra_cmd_queue.sv =====
// Short command queue between the front and back parts.
module bra_cmd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  bra_pkg::cmd_t       push_cmd,
    input  logic                pop,
    output bra_pkg::cmd_t       head,
    output bra_pkg::queue_stat_t stat
);
    import bra_pkg::*;

    cmd_t               slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_next;
    logic               do_push;
    logic               do_pop;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = slots[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed commands
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== src/bra_front.sv =====
// Front part: accepts requests, classifies them and fills the queue.
module bra_front (
    bra_req_if.sink             requests,
    input  bra_pkg::rows_t      rows,
    input  bra_pkg::queue_stat_t q_stat,
    output logic                push,
    output bra_pkg::cmd_t       push_cmd
);
    import bra_pkg::*;

    count_t [NUM_RES-1:0] value;
    count_t [NUM_RES-1:0] alloc;
    count_t [NUM_RES-1:0] need;

    assign requests.ready = !q_stat.full;
    assign push           = requests.valid && !q_stat.full;

    assign value = {requests.value_c, requests.value_b, requests.value_a};
    assign alloc = {requests.alloc_c, requests.alloc_b, requests.alloc_a};

    // Need is maximum minus allocation, clamped at zero
    always_comb
    begin
        for (int j = 0; j < NUM_RES; j++)
        begin
            need[j] = (value[j] > alloc[j]) ? value[j] - alloc[j] : '0;
        end
    end

    // Classify the action and build the command
    always_comb
    begin
        push_cmd.proc    = requests.process;
        push_cmd.alo     = alloc;
        push_cmd.val     = value;
        push_cmd.bad_row = ({1'b0, requests.process} >= rows);
        case (requests.action)
            OP_LOAD_AVAIL: push_cmd.op = OP_LOAD_AVAIL;
            OP_LOAD_ROW:
            begin
                push_cmd.op  = OP_LOAD_ROW;
                push_cmd.val = need;
            end
            OP_REQUEST:    push_cmd.op = OP_REQUEST;
            OP_SAFETY:     push_cmd.op = OP_SAFETY;
            default:       push_cmd.op = OP_SAFETY;
        endcase
    end

endmodule

// ===== src/bra_back.sv =====
// Back part: executes commands on the tables and drives the result register.
module bra_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bra_pkg::rows_t       rows,
    input  bra_pkg::cmd_t        head,
    input  bra_pkg::queue_stat_t q_stat,
    output logic                 pop,
    bra_res_if.source            results
);
    import bra_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_VERDICT
    } state_t;

    state_t               state_reg, state_next;
    count_t [NUM_RES-1:0] avail_reg, avail_next;
    count_t [NUM_RES-1:0] alloc_reg [MAX_PROCESSES];
    count_t [NUM_RES-1:0] need_reg  [MAX_PROCESSES];
    work_t  [NUM_RES-1:0] work_reg, work_next;
    logic [MAX_PROCESSES-1:0] marks_reg, marks_next;
    row_t                 row_reg, row_next;
    rows_t                idle_reg, idle_next;
    rows_t                remain_reg, remain_next;

    logic                 res_valid_reg, res_valid_next;
    logic [1:0]           res_kind_reg, res_kind_next;
    logic [1:0]           res_code_reg, res_code_next;
    row_t                 res_proc_reg, res_proc_next;
    logic                 res_safe_reg, res_safe_next;
    logic                 res_last_reg, res_last_next;

    row_t                 rd_row;
    count_t [NUM_RES-1:0] rd_alloc;
    count_t [NUM_RES-1:0] rd_need;
    logic                 row_we;
    count_t [NUM_RES-1:0] alloc_wdata;
    count_t [NUM_RES-1:0] need_wdata;
    verdict_t             req_code;
    logic                 fits;
    work_t  [NUM_RES-1:0] work_sum;
    rows_t                row_inc;
    rows_t                idle_inc;
    logic                 out_free;
    logic                 out_load;
    logic [1:0]           out_kind;
    logic [1:0]           out_code;
    row_t                 out_proc;
    logic                 out_safe;
    logic                 out_last;

    assign out_free = !res_valid_reg || results.ready;

    // Read one row: the scan row, or the row named by the queued command
    assign rd_row   = (state_reg == ST_SCAN) ? row_reg : head.proc;
    assign rd_alloc = alloc_reg[rd_row];
    assign rd_need  = need_reg[rd_row];

    // Request check: the first failing resource decides; over need is tested before over available
    always_comb
    begin
        logic found;
        found    = 1'b0;
        req_code = VC_GRANTED;
        for (int j = 0; j < NUM_RES; j++)
        begin
            if (!found)
            begin
                if (head.val[j] > rd_need[j])
                begin
                    req_code = VC_OVER_NEED;
                    found    = 1'b1;
                end
                else if (head.val[j] > avail_reg[j])
                begin
                    req_code = VC_OVER_AVAIL;
                    found    = 1'b1;
                end
            end
        end
    end

    // Scan row test and saturating work update
    always_comb
    begin
        logic [WORK_WIDTH:0] sum;
        fits = 1'b1;
        for (int j = 0; j < NUM_RES; j++)
        begin
            if (WORK_WIDTH'(rd_need[j]) > work_reg[j])
            begin
                fits = 1'b0;
            end
            sum = {1'b0, work_reg[j]} + (WORK_WIDTH + 1)'(rd_alloc[j]);
            work_sum[j] = (sum > {1'b0, WORK_MAX}) ? WORK_MAX : sum[WORK_WIDTH-1:0];
        end
    end

    assign row_inc  = {1'b0, row_reg} + 1'b1;
    assign idle_inc = idle_reg + 1'b1;

    // Sequence commands and the safety scan
    always_comb
    begin
        state_next  = state_reg;
        avail_next  = avail_reg;
        work_next   = work_reg;
        marks_next  = marks_reg;
        row_next    = row_reg;
        idle_next   = idle_reg;
        remain_next = remain_reg;
        pop         = 1'b0;
        row_we      = 1'b0;
        alloc_wdata = rd_alloc;
        need_wdata  = rd_need;
        out_load    = 1'b0;
        out_kind    = KIND_REQ_VERDICT;
        out_code    = VC_GRANTED;
        out_proc    = '0;
        out_safe    = 1'b0;
        out_last    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    case (head.op)
                        OP_LOAD_AVAIL:
                        begin
                            avail_next = head.val;
                            pop        = 1'b1;
                        end
                        OP_LOAD_ROW:
                        begin
                            row_we      = 1'b1;
                            alloc_wdata = head.alo;
                            need_wdata  = head.val;
                            pop         = 1'b1;
                        end
                        OP_REQUEST:
                        begin
                            if (out_free)
                            begin
                                pop      = 1'b1;
                                out_load = 1'b1;
                                out_last = 1'b1;
                                out_code = head.bad_row ? VC_BAD_PROCESS : req_code;
                                if (!head.bad_row && req_code == VC_GRANTED)
                                begin
                                    row_we = 1'b1;
                                    for (int j = 0; j < NUM_RES; j++)
                                    begin
                                        avail_next[j]  = avail_reg[j] - head.val[j];
                                        alloc_wdata[j] = rd_alloc[j] + head.val[j];
                                        need_wdata[j]  = rd_need[j] - head.val[j];
                                    end
                                end
                            end
                        end
                        OP_SAFETY:
                        begin
                            if (rows == '0)
                            begin
                                if (out_free)
                                begin
                                    pop      = 1'b1;
                                    out_load = 1'b1;
                                    out_kind = KIND_SAFETY;
                                    out_safe = 1'b1;
                                    out_last = 1'b1;
                                end
                            end
                            else
                            begin
                                pop = 1'b1;
                                for (int j = 0; j < NUM_RES; j++)
                                begin
                                    work_next[j] = WORK_WIDTH'(avail_reg[j]);
                                end
                                marks_next  = '0;
                                row_next    = '0;
                                idle_next   = '0;
                                remain_next = rows;
                                state_next  = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (out_free)
                begin
                    if (!marks_reg[row_reg] && fits)
                    begin
                        work_next           = work_sum;
                        marks_next[row_reg] = 1'b1;
                        remain_next         = remain_reg - 1'b1;
                        idle_next           = '0;
                        out_load            = 1'b1;
                        out_kind            = KIND_SEQ_ENTRY;
                        out_proc            = row_reg;
                        if (remain_reg == rows_t'(1))
                        begin
                            state_next = ST_VERDICT;
                        end
                    end
                    else
                    begin
                        idle_next = idle_inc;
                        if (idle_inc >= rows)
                        begin
                            state_next = ST_VERDICT;
                        end
                    end
                    row_next = (row_inc >= rows) ? '0 : row_inc[ROW_W-1:0];
                end
            end
            ST_VERDICT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_kind   = KIND_SAFETY;
                    out_safe   = (remain_reg == '0);
                    out_last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Load the result register, drop it once taken
    always_comb
    begin
        res_valid_next = out_load ? 1'b1 : (results.ready ? 1'b0 : res_valid_reg);
        res_kind_next  = out_load ? out_kind : res_kind_reg;
        res_code_next  = out_load ? out_code : res_code_reg;
        res_proc_next  = out_load ? out_proc : res_proc_reg;
        res_safe_next  = out_load ? out_safe : res_safe_reg;
        res_last_next  = out_load ? out_last : res_last_reg;
    end

    assign results.valid            = res_valid_reg;
    assign results.kind             = res_kind_reg;
    assign results.verdict_code     = res_code_reg;
    assign results.sequence_process = res_proc_reg;
    assign results.is_safe          = res_safe_reg;
    assign results.last             = res_last_reg;

    // Hold state, tables and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            avail_reg     <= '0;
            work_reg      <= '0;
            marks_reg     <= '0;
            row_reg       <= '0;
            idle_reg      <= '0;
            remain_reg    <= '0;
            res_valid_reg <= 1'b0;
            res_kind_reg  <= '0;
            res_code_reg  <= '0;
            res_proc_reg  <= '0;
            res_safe_reg  <= 1'b0;
            res_last_reg  <= 1'b0;
            for (int i = 0; i < MAX_PROCESSES; i++)
            begin
                alloc_reg[i] <= '0;
                need_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            avail_reg     <= avail_next;
            work_reg      <= work_next;
            marks_reg     <= marks_next;
            row_reg       <= row_next;
            idle_reg      <= idle_next;
            remain_reg    <= remain_next;
            res_valid_reg <= res_valid_next;
            res_kind_reg  <= res_kind_next;
            res_code_reg  <= res_code_next;
            res_proc_reg  <= res_proc_next;
            res_safe_reg  <= res_safe_next;
            res_last_reg  <= res_last_next;
            if (row_we)
            begin
                alloc_reg[rd_row] <= alloc_wdata;
                need_reg[rd_row]  <= need_wdata;
            end
        end
    end

    // Commands leave the queue only when one is there
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("command popped from empty queue");

    // A new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result register overwritten");

    // Finished rows plus remaining rows account for every taking-part row
    a_scan_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |->
            ($countones(marks_reg) + int'(remain_reg)) == int'(rows))
        else $error("scan bookkeeping lost a row");

    // The scan stops before running out of rows or idle steps
    a_scan_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> (remain_reg != '0 && idle_reg < rows))
        else $error("scan continued past its end");

endmodule
